// File: src/fsep_pkg.sv
// ----------------------------------------------------------------------------
// fsep_pkg
// Types and codes shared by the flow start/end pairing table.
// ----------------------------------------------------------------------------
package fsep_pkg;

  localparam logic [1:0] ModeNew     = 2'd0;
  localparam logic [1:0] ModeDestroy = 2'd1;
  localparam logic [1:0] ModeFlush   = 2'd2;
  localparam logic [1:0] ModeOther   = 2'd3;

  localparam logic [1:0] StPaired   = 2'd0;
  localparam logic [1:0] StNoStart  = 2'd1;
  localparam logic [1:0] StFlushed  = 2'd2;
  localparam logic [1:0] StDropped  = 2'd3;

  localparam int unsigned RankW = 4;

  typedef struct packed {
    logic [63:0] oips;
    logic [63:0] rips;
    logic [63:0] ports;
    logic [63:0] start;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_READ, S_EVAL, S_EMIT, S_FLUSH
  } state_e;

endpackage

// File: src/fsep_ram.sv
// ----------------------------------------------------------------------------
// fsep_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fsep_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: src/flow_start_end_pairing_table.sv
// ----------------------------------------------------------------------------
// flow_start_end_pairing_table
// Connection tracking table pairing start and end events per flow tuple.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one event per transfer:
// mode, both address/port tuples, a timestamp and a flush bucket index.
// Output channel (out_valid_o/out_ready_i) carries one record per transfer,
// last_of_run marking the final record caused by an input.
// Each bucket is one memory row holding all ways (tuple, start time, rank)
// plus a valid mask; one row read, a parallel compare of all ways and one
// row write-back make up an item. New and destroy items step through the
// read and evaluate states, and the evaluate state loads any record into
// the output register. A flush emits one record per rank present in the
// row, then writes the row back with its valid mask cleared. The single
// row port of the bucket memory serializes the items.
// After reset a clearing pass zeroes the valid mask of every bucket, one
// row per cycle, with in_ready_o low. A stalled receiver holds the record
// in the output register and the block accepts nothing more until it is
// taken.
// ----------------------------------------------------------------------------
module flow_start_end_pairing_table
  import fsep_pkg::*;
#(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] orig_src_ip_i,
  input  logic [31:0] orig_dst_ip_i,
  input  logic [31:0] repl_src_ip_i,
  input  logic [31:0] repl_dst_ip_i,
  input  logic [15:0] orig_src_port_i,
  input  logic [15:0] orig_dst_port_i,
  input  logic [15:0] repl_src_port_i,
  input  logic [15:0] repl_dst_port_i,
  input  logic [63:0] event_time_i,
  input  logic [9:0]  flush_bucket_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_orig_src_ip_o,
  output logic [31:0] out_orig_dst_ip_o,
  output logic [31:0] out_repl_src_ip_o,
  output logic [31:0] out_repl_dst_ip_o,
  output logic [15:0] out_orig_src_port_o,
  output logic [15:0] out_orig_dst_port_o,
  output logic [15:0] out_repl_src_port_o,
  output logic [15:0] out_repl_dst_port_o,
  output logic [63:0] create_time_o,
  output logic [63:0] destroy_time_o,
  output logic [1:0]  record_status_o,
  output logic        last_of_run_o
);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WIW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned EW = $bits(entry_t);
  localparam int unsigned RW = WAYS * (EW + RankW) + WAYS;
  localparam logic [BW-1:0] LastB = BW'(BUCKETS - 1);

  typedef struct packed {
    logic [WAYS-1:0][RankW-1:0] rank;
    entry_t [WAYS-1:0]          ent;
    logic [WAYS-1:0]            vld;
  } row_t;

  state_e state_q, state_d;
  logic [BW-1:0] addr_q, addr_d;
  logic [1:0] mode_q;
  entry_t in_q;
  logic [63:0] time_q;
  row_t row_rd, row_q, row_wr;
  logic we;
  logic [BW-1:0] ram_addr;
  logic [RankW-1:0] rk_q;

  logic ov_q, ov_d;
  entry_t oe_q, oe_d;
  logic [63:0] ct_q, ct_d, dt_q, dt_d;
  logic [1:0] os_q, os_d;
  logic ol_q, ol_d;
  logic load_in, cap_row;
  logic [RankW-1:0] rk_d;

  fsep_ram #(.Width(RW), .Depth(BUCKETS)) u_ram (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(row_wr), .rdata_o(row_rd)
  );

  // hash of the incoming tuple
  logic [31:0] h;
  logic [BW-1:0] hb;
  always_comb begin
    h = orig_src_ip_i ^ orig_dst_ip_i ^ repl_src_ip_i ^ repl_dst_ip_i ^
        {16'd0, orig_src_port_i} ^ {16'd0, orig_dst_port_i} ^
        {16'd0, repl_src_port_i} ^ {16'd0, repl_dst_port_i};
    h = (h >> 16) ^ h;
    hb = BW'(h % BUCKETS);
  end

  // way evaluation on the captured row
  logic [WAYS-1:0] match;
  logic found, freefound;
  logic [WIW-1:0] fi, fr;
  logic [RankW-1:0] cnt;
  logic [WAYS-1:0] rsel;
  logic rany;
  always_comb begin
    found = 1'b0; freefound = 1'b0; fi = '0; fr = '0; cnt = '0;
    rsel = '0; rany = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_q.vld[w] && row_q.ent[w].oips == in_q.oips &&
                 row_q.ent[w].rips == in_q.rips && row_q.ent[w].ports == in_q.ports;
      if (row_q.vld[w]) cnt = cnt + 1'b1;
      else if (!freefound) begin
        freefound = 1'b1; fr = WIW'(w);
      end
      if (match[w] && (!found || row_q.rank[w] < row_q.rank[fi])) begin
        found = 1'b1; fi = WIW'(w);
      end
      if (row_q.vld[w] && row_q.rank[w] == rk_q && !rany) begin
        rany = 1'b1; rsel[w] = 1'b1;
      end
    end
  end

  // rank still pending in a flush: any later rank present
  logic more;
  always_comb begin
    more = 1'b0;
    for (int w = 0; w < WAYS; w++)
      if (row_q.vld[w] && row_q.rank[w] > rk_q) more = 1'b1;
  end

  entry_t fsel;
  always_comb begin
    fsel = row_q.ent[0];
    for (int w = 0; w < WAYS; w++) if (rsel[w]) fsel = row_q.ent[w];
  end

  always_comb begin
    state_d = state_q; addr_d = addr_q; we = 1'b0; ram_addr = addr_q;
    row_wr = row_q; ov_d = ov_q; oe_d = oe_q; ct_d = ct_q; dt_d = dt_q;
    os_d = os_q; ol_d = ol_q; load_in = 1'b0; cap_row = 1'b0; rk_d = rk_q;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1; row_wr = '0;
        addr_d = addr_q + 1'b1;
        if (addr_q == LastB) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          load_in = 1'b1;
          addr_d = (mode_i == ModeFlush) ? BW'(flush_bucket_i % BUCKETS) : hb;
          ram_addr = addr_d;
          state_d = (mode_i == ModeOther) ? S_IDLE : S_READ;
        end
      end
      S_READ: begin
        cap_row = 1'b1; rk_d = '0;
        state_d = (mode_q == ModeFlush) ? S_FLUSH : S_EVAL;
      end
      S_EVAL: begin
        state_d = S_IDLE;
        if (mode_q == ModeNew) begin
          if (freefound) begin
            we = 1'b1;
            row_wr.vld[fr] = 1'b1;
            row_wr.ent[fr] = in_q;
            row_wr.rank[fr] = cnt;
          end else begin
            ov_d = 1'b1; oe_d = in_q; ct_d = time_q; dt_d = '0;
            os_d = StDropped; ol_d = 1'b1;
          end
        end else begin
          ov_d = 1'b1; oe_d = in_q; dt_d = time_q; ol_d = 1'b1;
          if (found) begin
            ct_d = row_q.ent[fi].start; os_d = StPaired;
            we = 1'b1;
            row_wr.vld[fi] = 1'b0;
            for (int w = 0; w < WAYS; w++)
              if (row_q.vld[w] && row_q.rank[w] > row_q.rank[fi])
                row_wr.rank[w] = row_q.rank[w] - 1'b1;
          end else begin
            ct_d = '0; os_d = StNoStart;
          end
        end
      end
      S_FLUSH: begin
        if (!ov_q || out_ready_i) begin
          if (rany) begin
            ov_d = 1'b1; oe_d = fsel;
            ct_d = fsel.start; dt_d = '0; os_d = StFlushed; ol_d = !more;
          end
          rk_d = rk_q + 1'b1;
          if (!more) begin
            we = 1'b1; row_wr.vld = '0; state_d = S_EMIT;
          end
        end
      end
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; addr_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; addr_q <= addr_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      mode_q <= mode_i;
      in_q <= '{oips: {orig_src_ip_i, orig_dst_ip_i}, rips: {repl_src_ip_i, repl_dst_ip_i},
                ports: {orig_src_port_i, orig_dst_port_i, repl_src_port_i,
                        repl_dst_port_i}, start: event_time_i};
      time_q <= event_time_i;
    end
    if (cap_row) row_q <= row_rd;
    rk_q <= rk_d;
    oe_q <= oe_d; ct_q <= ct_d; dt_q <= dt_d; os_q <= os_d; ol_q <= ol_d;
  end

  assign out_valid_o         = ov_q;
  assign out_orig_src_ip_o   = oe_q.oips[63:32];
  assign out_orig_dst_ip_o   = oe_q.oips[31:0];
  assign out_repl_src_ip_o   = oe_q.rips[63:32];
  assign out_repl_dst_ip_o   = oe_q.rips[31:0];
  assign out_orig_src_port_o = oe_q.ports[63:48];
  assign out_orig_dst_port_o = oe_q.ports[47:32];
  assign out_repl_src_port_o = oe_q.ports[31:16];
  assign out_repl_dst_port_o = oe_q.ports[15:0];
  assign create_time_o       = ct_q;
  assign destroy_time_o      = dt_q;
  assign record_status_o     = os_q;
  assign last_of_run_o       = ol_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o) else $error("accept during clear");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(create_time_o))
    else $error("output dropped");
  a_flush_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> record_status_o == StFlushed)
    else $error("non-last record outside flush");
endmodule
